// ===== rtl/core/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, register codes and defaults of the triangle pixel coverage
// block.
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int SCREEN_SIZE   = 1024;
   localparam int FRACTION_BITS = 4;

   localparam int NUM_VERTS = 3;
   localparam int VERTEX_W  = 15;
   localparam int COLOR_W   = 16;
   localparam int LWIDTH_W  = 11;
   localparam int PIXEL_W   = 10;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RESET = 11'd320;

   localparam logic [REG_IDX_W-1:0] REG_VERTEX0_X  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_VERTEX0_Y  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_VERTEX1_X  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_VERTEX1_Y  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_VERTEX2_X  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_VERTEX2_Y  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_FILL_COLOR = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH = 3'd7;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_x;
      logic [PIXEL_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] out_x;
      logic [PIXEL_W-1:0] out_y;
      logic               covered;
      logic [COLOR_W-1:0] out_color;
   } rsp_type;

   typedef struct packed {
      logic [NUM_VERTS-1:0][VERTEX_W-1:0] vert_x;
      logic [NUM_VERTS-1:0][VERTEX_W-1:0] vert_y;
      logic [COLOR_W-1:0]                 fill_color;
      logic [LWIDTH_W-1:0]                line_width;
   } cfg_type;

endpackage

// ===== rtl/core/tpc_csr.sv =====
// ----------------------------------------------------------------------------
// tpc_csr
// Configuration register file: vertices, fill color and line width behind an
// APB-style port.
// ----------------------------------------------------------------------------
module tpc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tpc_pkg::ADDR_W-1:0]  paddr,
   input  logic [tpc_pkg::DATA_W-1:0]  pwdata,
   output logic [tpc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output tpc_pkg::cfg_type            cfg
);

   localparam tpc_pkg::cfg_type CFG_RESET = '{
      vert_x:     '0,
      vert_y:     '0,
      fill_color: '0,
      line_width: tpc_pkg::LINE_WIDTH_RESET
   };

   tpc_pkg::cfg_type                    cfg_ff;
   tpc_pkg::cfg_type                    cfg_in;
   logic [tpc_pkg::REG_IDX_W-1:0]       reg_idx;
   logic                                wr_en;

   assign reg_idx = paddr[tpc_pkg::ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            tpc_pkg::REG_VERTEX0_X:  cfg_in.vert_x[0]  = pwdata[tpc_pkg::VERTEX_W-1:0];
            tpc_pkg::REG_VERTEX0_Y:  cfg_in.vert_y[0]  = pwdata[tpc_pkg::VERTEX_W-1:0];
            tpc_pkg::REG_VERTEX1_X:  cfg_in.vert_x[1]  = pwdata[tpc_pkg::VERTEX_W-1:0];
            tpc_pkg::REG_VERTEX1_Y:  cfg_in.vert_y[1]  = pwdata[tpc_pkg::VERTEX_W-1:0];
            tpc_pkg::REG_VERTEX2_X:  cfg_in.vert_x[2]  = pwdata[tpc_pkg::VERTEX_W-1:0];
            tpc_pkg::REG_VERTEX2_Y:  cfg_in.vert_y[2]  = pwdata[tpc_pkg::VERTEX_W-1:0];
            tpc_pkg::REG_FILL_COLOR: cfg_in.fill_color = pwdata[tpc_pkg::COLOR_W-1:0];
            tpc_pkg::REG_LINE_WIDTH: cfg_in.line_width = pwdata[tpc_pkg::LWIDTH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         tpc_pkg::REG_VERTEX0_X:  prdata = tpc_pkg::DATA_W'(cfg_ff.vert_x[0]);
         tpc_pkg::REG_VERTEX0_Y:  prdata = tpc_pkg::DATA_W'(cfg_ff.vert_y[0]);
         tpc_pkg::REG_VERTEX1_X:  prdata = tpc_pkg::DATA_W'(cfg_ff.vert_x[1]);
         tpc_pkg::REG_VERTEX1_Y:  prdata = tpc_pkg::DATA_W'(cfg_ff.vert_y[1]);
         tpc_pkg::REG_VERTEX2_X:  prdata = tpc_pkg::DATA_W'(cfg_ff.vert_x[2]);
         tpc_pkg::REG_VERTEX2_Y:  prdata = tpc_pkg::DATA_W'(cfg_ff.vert_y[2]);
         tpc_pkg::REG_FILL_COLOR: prdata = tpc_pkg::DATA_W'(cfg_ff.fill_color);
         tpc_pkg::REG_LINE_WIDTH: prdata = tpc_pkg::DATA_W'(cfg_ff.line_width);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/tpc_pipe.sv =====
// ----------------------------------------------------------------------------
// tpc_pipe
// Coverage datapath: bounding box test and edge/area products in the first
// stage, sums, winding correction and thresholds in the second.
// ----------------------------------------------------------------------------
module tpc_pipe #(
   parameter int SCREEN_SIZE   = tpc_pkg::SCREEN_SIZE,
   parameter int FRACTION_BITS = tpc_pkg::FRACTION_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  tpc_pkg::req_type req_data,
   input  tpc_pkg::cfg_type cfg,
   output logic             rsp_strobe,
   output tpc_pkg::rsp_type rsp_data
);

   localparam int VW  = tpc_pkg::VERTEX_W;
   localparam int VDW = VW + 1;
   localparam int CW  = 12 + FRACTION_BITS;
   localparam int DW  = ((CW > VDW) ? CW : VDW) + 1;
   localparam int PW  = VDW + DW;
   localparam int EW  = PW + 1;
   localparam int AW  = 2 * VDW;
   localparam int BW  = 17;
   localparam int WW  = 13;

   localparam int AREA_MIN    = ((1 << (2 * FRACTION_BITS)) + 3) / 4;
   localparam int EDGE_MARGIN = (7 * (1 << (2 * FRACTION_BITS + 1))) / 20;

   localparam logic signed [AW:0]   AREA_POS  = (AW+1)'(AREA_MIN);
   localparam logic signed [AW:0]   AREA_NEG  = -((AW+1)'(AREA_MIN));
   localparam logic signed [EW-1:0] EDGE_POS  = EW'(EDGE_MARGIN);
   localparam logic signed [EW-1:0] EDGE_NEG  = -(EW'(EDGE_MARGIN));
   localparam logic signed [BW-1:0] CEIL_ADD  = BW'((1 << FRACTION_BITS) - 1);
   localparam logic [WW-1:0]        WIDTH_LIM = WW'(SCREEN_SIZE);

   function automatic logic signed [VW-1:0] min3(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b,
                                                 input logic signed [VW-1:0] c);
      logic signed [VW-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [VW-1:0] max3(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b,
                                                 input logic signed [VW-1:0] c);
      logic signed [VW-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   logic signed [VW-1:0] vx [tpc_pkg::NUM_VERTS];
   logic signed [VW-1:0] vy [tpc_pkg::NUM_VERTS];

   logic [CW-1:0]         cx;
   logic [CW-1:0]         cy;
   logic signed [PW-1:0]  ea_in [tpc_pkg::NUM_VERTS];
   logic signed [PW-1:0]  eb_in [tpc_pkg::NUM_VERTS];
   logic signed [PW-1:0]  ea_ff [tpc_pkg::NUM_VERTS];
   logic signed [PW-1:0]  eb_ff [tpc_pkg::NUM_VERTS];
   logic signed [AW-1:0]  aa_in, ab_in, aa_ff, ab_ff;
   logic signed [VDW-1:0] dx10, dy20, dx20, dy10;

   logic signed [BW-1:0]  left, right_ceil, top, bottom, px_s, py_s;
   logic [WW-1:0]         width_eff;
   logic                  box_in, box_ff;
   logic                  s1_valid_ff;
   tpc_pkg::req_type      s1_req_ff;

   logic signed [AW:0]    area;
   logic                  area_neg, area_ok;
   logic signed [EW-1:0]  edge_sum [tpc_pkg::NUM_VERTS];
   logic [tpc_pkg::NUM_VERTS-1:0] edge_ok;
   logic                  cov;
   tpc_pkg::rsp_type      rsp_in, rsp_ff;
   logic                  rsp_valid_ff;

   always_comb begin
      for (int k = 0; k < tpc_pkg::NUM_VERTS; k++) begin
         vx[k] = $signed(cfg.vert_x[k]);
         vy[k] = $signed(cfg.vert_y[k]);
      end
   end

   assign cx = {{(CW-11){1'b0}}, req_data.pixel_x, 1'b1} << FRACTION_BITS;
   assign cy = {{(CW-11){1'b0}}, req_data.pixel_y, 1'b1} << FRACTION_BITS;

   for (genvar g = 0; g < tpc_pkg::NUM_VERTS; g++) begin : g_edge
      localparam int I = (g + 1) % 3;
      localparam int J = (g + 2) % 3;
      logic signed [VDW-1:0] ey, ex;
      logic signed [DW-1:0]  dcx, dcy;
      assign ey  = VDW'(vy[I]) - VDW'(vy[J]);
      assign ex  = VDW'(vx[J]) - VDW'(vx[I]);
      assign dcx = DW'($signed({1'b0, cx})) - DW'($signed({vx[I], 1'b0}));
      assign dcy = DW'($signed({1'b0, cy})) - DW'($signed({vy[I], 1'b0}));
      assign ea_in[g] = ey * dcx;
      assign eb_in[g] = ex * dcy;
   end

   assign dx10  = VDW'(vx[1]) - VDW'(vx[0]);
   assign dy20  = VDW'(vy[2]) - VDW'(vy[0]);
   assign dx20  = VDW'(vx[2]) - VDW'(vx[0]);
   assign dy10  = VDW'(vy[1]) - VDW'(vy[0]);
   assign aa_in = dx10 * dy20;
   assign ab_in = dx20 * dy10;

   always_comb begin
      left       = BW'(min3(vx[0], vx[1], vx[2]) >>> FRACTION_BITS);
      right_ceil = (BW'(max3(vx[0], vx[1], vx[2])) + CEIL_ADD) >>> FRACTION_BITS;
      top        = BW'(min3(vy[0], vy[1], vy[2]) >>> FRACTION_BITS);
      bottom     = (BW'(max3(vy[0], vy[1], vy[2])) + CEIL_ADD) >>> FRACTION_BITS;
      px_s       = $signed({{(BW-tpc_pkg::PIXEL_W){1'b0}}, req_data.pixel_x});
      py_s       = $signed({{(BW-tpc_pkg::PIXEL_W){1'b0}}, req_data.pixel_y});
      width_eff  = ({2'b00, cfg.line_width} > WIDTH_LIM) ? WIDTH_LIM
                                                         : {2'b00, cfg.line_width};
      box_in     = (px_s >= left) && (px_s <= right_ceil)
                && ({{(WW-tpc_pkg::PIXEL_W){1'b0}}, req_data.pixel_x} < width_eff)
                && (py_s >= top) && (py_s <= bottom);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= req_data;
      box_ff    <= box_in;
      aa_ff     <= aa_in;
      ab_ff     <= ab_in;
      ea_ff     <= ea_in;
      eb_ff     <= eb_in;
   end

   always_comb begin
      area     = (AW+1)'(aa_ff) - (AW+1)'(ab_ff);
      area_neg = area[AW];
      area_ok  = (area >= AREA_POS) || (area <= AREA_NEG);
      for (int k = 0; k < tpc_pkg::NUM_VERTS; k++) begin
         edge_sum[k] = EW'(ea_ff[k]) + EW'(eb_ff[k]);
         edge_ok[k]  = area_neg ? (edge_sum[k] <= EDGE_POS) : (edge_sum[k] >= EDGE_NEG);
      end
      cov              = box_ff & area_ok & (&edge_ok);
      rsp_in.out_x     = s1_req_ff.pixel_x;
      rsp_in.out_y     = s1_req_ff.pixel_y;
      rsp_in.covered   = cov;
      rsp_in.out_color = cov ? cfg.fill_color : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== rtl/core/triangle_pixel_coverage_top.sv =====
// ----------------------------------------------------------------------------
// triangle_pixel_coverage_top
// Per-pixel coverage test of one filled triangle against edge functions,
// area and bounding box.
//
// Program the three vertices (signed fixed point), fill color and line width
// through the APB port while no pixel is in flight. Each register sits at
// byte address 4 * index; pready is always high.
// Pixels enter on start with req_data; busy never rises, so one pixel is
// taken every clock. Each pixel gives exactly one transfer on rsp_strobe /
// rsp_data: the first stage forms the bounding box test and the edge and
// area products, the second sums and thresholds them into a registered
// result. Throughput is one pixel per clock.
// The receiver cannot stall; every result is shown for a single cycle.
// Reset clears the pipeline valid flags, zeroes the vertices and color and
// sets the line width to 320.
// ----------------------------------------------------------------------------
module triangle_pixel_coverage_top #(
   parameter int SCREEN_SIZE   = tpc_pkg::SCREEN_SIZE,
   parameter int FRACTION_BITS = tpc_pkg::FRACTION_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  tpc_pkg::req_type            req_data,
   output logic                        rsp_strobe,
   output tpc_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tpc_pkg::ADDR_W-1:0]  paddr,
   input  logic [tpc_pkg::DATA_W-1:0]  pwdata,
   output logic [tpc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   tpc_pkg::cfg_type cfg;

   assign busy = 1'b0;

   tpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tpc_pipe #(
      .SCREEN_SIZE   (SCREEN_SIZE),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .cfg        (cfg),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== tb/tb_triangle_pixel_coverage_top.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_pixel_coverage_top
// Self-checking bench for the triangle pixel coverage block. Triangles, fill
// color and line width are programmed over APB while the pipe is empty, then
// pixel transfers stream in with random gaps. A scoreboard predicts coverage
// per pixel from its own copy of the registers and checks every result
// transfer in order. Directed triangles cover the vertex and pixel extremes,
// area threshold, winding, zero and saturated widths; random phases follow.
// ----------------------------------------------------------------------------
module tb_triangle_pixel_coverage_top;
   import tpc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 25;

   class coverage_scoreboard;
      longint      vert_x[3];
      longint      vert_y[3];
      logic [15:0] color;
      logic [10:0] lwidth;
      rsp_type     expected_pixels[$];
      int          errors;

      function new();
         for (int i = 0; i < 3; i++) begin
            vert_x[i] = 0;
            vert_y[i] = 0;
         end
         color  = '0;
         lwidth = LINE_WIDTH_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
         logic signed [VERTEX_W-1:0] vtx;
         vtx = data[VERTEX_W-1:0];
         case (idx)
            REG_VERTEX0_X:  vert_x[0] = vtx;
            REG_VERTEX0_Y:  vert_y[0] = vtx;
            REG_VERTEX1_X:  vert_x[1] = vtx;
            REG_VERTEX1_Y:  vert_y[1] = vtx;
            REG_VERTEX2_X:  vert_x[2] = vtx;
            REG_VERTEX2_Y:  vert_y[2] = vtx;
            REG_FILL_COLOR: color = data[COLOR_W-1:0];
            REG_LINE_WIDTH: lwidth = data[LWIDTH_W-1:0];
            default: ;
         endcase
      endfunction

      function longint min3(longint a, longint b, longint c);
         longint m;
         m = (a < b) ? a : b;
         return (m < c) ? m : c;
      endfunction

      function longint max3(longint a, longint b, longint c);
         longint m;
         m = (a > b) ? a : b;
         return (m > c) ? m : c;
      endfunction

      function longint floor_fx(longint v);
         return v >>> FRACTION_BITS;
      endfunction

      function rsp_type predict_coverage(req_type r);
         rsp_type o;
         longint  px, py, area, abs_area, w;
         longint  left, right, top, bottom;
         longint  cx, cy, e12, e20, e01, limit;
         bit      cov;
         px = r.pixel_x;
         py = r.pixel_y;
         area = (vert_x[1] - vert_x[0]) * (vert_y[2] - vert_y[0])
              - (vert_x[2] - vert_x[0]) * (vert_y[1] - vert_y[0]);
         abs_area = (area < 0) ? -area : area;
         w = lwidth;
         if (w > SCREEN_SIZE) w = SCREEN_SIZE;
         cov = (4 * abs_area >= (longint'(1) << (2 * FRACTION_BITS)));
         left   = floor_fx(min3(vert_x[0], vert_x[1], vert_x[2]));
         right  = -floor_fx(-max3(vert_x[0], vert_x[1], vert_x[2]));
         top    = floor_fx(min3(vert_y[0], vert_y[1], vert_y[2]));
         bottom = -floor_fx(-max3(vert_y[0], vert_y[1], vert_y[2]));
         if (left < 0) left = 0;
         if (right > w - 1) right = w - 1;
         if (px < left || px > right || py < top || py > bottom) cov = 0;
         if (cov) begin
            cx = (2 * px + 1) << FRACTION_BITS;
            cy = (2 * py + 1) << FRACTION_BITS;
            e12 = (vert_y[1] - vert_y[2]) * (cx - 2 * vert_x[1])
                + (vert_x[2] - vert_x[1]) * (cy - 2 * vert_y[1]);
            e20 = (vert_y[2] - vert_y[0]) * (cx - 2 * vert_x[2])
                + (vert_x[0] - vert_x[2]) * (cy - 2 * vert_y[2]);
            e01 = (vert_y[0] - vert_y[1]) * (cx - 2 * vert_x[0])
                + (vert_x[1] - vert_x[0]) * (cy - 2 * vert_y[0]);
            limit = -(7 * (longint'(1) << (2 * FRACTION_BITS + 1)));
            if (area < 0) begin
               e12 = -e12;
               e20 = -e20;
               e01 = -e01;
            end
            if (20 * e12 < limit || 20 * e20 < limit || 20 * e01 < limit) cov = 0;
         end
         o.out_x     = r.pixel_x;
         o.out_y     = r.pixel_y;
         o.covered   = cov;
         o.out_color = cov ? color : '0;
         return o;
      endfunction

      function void note_pixel(req_type r);
         expected_pixels.push_back(predict_coverage(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (expected_pixels.size() == 0) begin
            $error("result transfer with no pixel pending: x %0d y %0d",
                   got.out_x, got.out_y);
            errors++;
            return;
         end
         exp = expected_pixels.pop_front();
         if (got.out_x !== exp.out_x) begin
            $error("out_x expected %0d actual %0d", exp.out_x, got.out_x);
            errors++;
         end
         if (got.out_y !== exp.out_y) begin
            $error("out_y expected %0d actual %0d", exp.out_y, got.out_y);
            errors++;
         end
         if (got.covered !== exp.covered) begin
            $error("covered expected %0d actual %0d (x %0d y %0d)",
                   exp.covered, got.covered, exp.out_x, exp.out_y);
            errors++;
         end
         if (got.out_color !== exp.out_color) begin
            $error("out_color expected %h actual %h", exp.out_color, got.out_color);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset   = 1'b1;
   logic                start   = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                psel    = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite  = 1'b0;
   logic [ADDR_W-1:0]   paddr   = '0;
   logic [DATA_W-1:0]   pwdata  = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   coverage_scoreboard sb = new();
   int                 idle_cycles = 0;
   bit                 allow_gaps;

   triangle_pixel_coverage_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_result(rsp_data);
         if (start && !busy) sb.note_pixel(req_data);
      end
      if ((start && !busy) || rsp_strobe || (psel && penable && pwrite && pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input int value);
      logic [DATA_W-1:0] data;
      data = $urandom;
      if (idx == REG_FILL_COLOR) data[COLOR_W-1:0] = value[COLOR_W-1:0];
      else if (idx == REG_LINE_WIDTH) data[LWIDTH_W-1:0] = value[LWIDTH_W-1:0];
      else data[VERTEX_W-1:0] = value[VERTEX_W-1:0];
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, data);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_triangle(input int x0, y0, x1, y1, x2, y2, color, width);
      csr_write(REG_VERTEX0_X, x0);
      csr_write(REG_VERTEX0_Y, y0);
      csr_write(REG_VERTEX1_X, x1);
      csr_write(REG_VERTEX1_Y, y1);
      csr_write(REG_VERTEX2_X, x2);
      csr_write(REG_VERTEX2_Y, y2);
      csr_write(REG_FILL_COLOR, color);
      csr_write(REG_LINE_WIDTH, width);
   endtask

   task automatic send_pixel(input int x, y);
      int gap;
      int pick;
      gap = 0;
      if (allow_gaps) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) gap = 0;
         else if (pick < 90) gap = $urandom_range(1, 3);
         else gap = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data.pixel_x <= x[PIXEL_W-1:0];
      req_data.pixel_y <= y[PIXEL_W-1:0];
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_pipe();
      start <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_phase();
      int cxp, cyp, span, n, px, py, color, width, pick;
      int v[6];
      cxp  = $urandom_range(0, 1023);
      cyp  = $urandom_range(0, 1023);
      span = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40) : $urandom_range(41, 300);
      pick = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) begin
         if (pick == 0) begin
            v[i] = int'($urandom_range(0, 32767)) - 16384;
         end else begin
            v[i] = ((i % 2 == 0) ? cxp : cyp) + int'($urandom_range(0, 2 * span)) - span;
            v[i] = clamp_int(v[i] * 16 + int'($urandom_range(0, 15)), -16384, 16383);
         end
      end
      if (pick == 1) begin
         v[4] = v[0];
         v[5] = v[1];
      end
      color = $urandom_range(0, 65535);
      pick  = $urandom_range(0, 99);
      if (pick < 50) width = 1024;
      else if (pick < 70) width = $urandom_range(1, 1024);
      else if (pick < 80) width = $urandom_range(1025, 2047);
      else if (pick < 85) width = 0;
      else width = clamp_int(cxp + int'($urandom_range(0, 2 * span)) - span, 1, 1024);
      program_triangle(v[0], v[1], v[2], v[3], v[4], v[5], color, width);
      allow_gaps = ($urandom_range(0, 3) != 0);
      n = $urandom_range(30, 70);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) < 7) begin
            px = clamp_int(cxp + int'($urandom_range(0, 2 * span + 4)) - span - 2, 0, 1023);
            py = clamp_int(cyp + int'($urandom_range(0, 2 * span + 4)) - span - 2, 0, 1023);
         end else begin
            px = $urandom_range(0, 1023);
            py = $urandom_range(0, 1023);
         end
         send_pixel(px, py);
      end
      drain_pipe();
   endtask

   initial begin
      allow_gaps = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: all vertices at the origin
      send_pixel(0, 0);
      send_pixel(5, 5);
      drain_pipe();

      program_triangle(-16384, -16384, 16383, -16384, -16384, 16383, 16'hFFFF, 1024);
      send_pixel(0, 0);
      send_pixel(1023, 0);
      send_pixel(0, 1023);
      send_pixel(1023, 1023);
      send_pixel(512, 512);
      drain_pipe();

      csr_write(REG_LINE_WIDTH, 0);
      send_pixel(0, 0);
      send_pixel(3, 3);
      drain_pipe();

      csr_write(REG_LINE_WIDTH, 2047);
      send_pixel(1023, 5);
      send_pixel(1023, 1023);
      drain_pipe();

      csr_write(REG_LINE_WIDTH, 1);
      send_pixel(0, 0);
      send_pixel(1, 0);
      drain_pipe();

      // twice the area right at the limit, then just below it
      program_triangle(0, 0, 8, 0, 0, 8, 16'h1234, 320);
      send_pixel(0, 0);
      drain_pipe();
      program_triangle(0, 0, 7, 0, 0, 9, 16'h1234, 320);
      send_pixel(0, 0);
      drain_pipe();

      // clockwise winding
      program_triangle(0, 0, 0, 160, 160, 0, 16'hA5A5, 320);
      send_pixel(3, 3);
      send_pixel(9, 9);
      send_pixel(15, 15);
      drain_pipe();

      // collinear vertices
      program_triangle(0, 0, 160, 160, 320, 320, 16'h5A5A, 320);
      send_pixel(5, 5);
      drain_pipe();

      for (int p = 0; p < RANDOM_PHASES; p++) random_phase();

      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
